>>> hdl/prh_pkg.sv
// prh_pkg: widths, register map, reset values and shared types of the
// polynomial rolling hash unit; used by every other file of the block
`default_nettype none

package prh_pkg;

    // payload widths
    localparam int BYTE_W = 8;
    localparam int HASH_W = 32;
    localparam int ACC_W  = 2 * HASH_W;
    localparam int CNT_W  = $clog2(ACC_W);

    // configuration port
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_MULTIPLIER = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_MODULUS    = REG_IDX_W'(1);

    localparam logic [HASH_W-1:0] RESET_MULTIPLIER = HASH_W'(911382323);
    localparam logic [HASH_W-1:0] RESET_MODULUS    = HASH_W'(972663749);

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic [HASH_W-1:0] multiplier;
        logic [HASH_W-1:0] modulus;
    } cfg_t;

    // request to the remainder unit
    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  dividend;
        logic [HASH_W-1:0] divisor;
    } rem_req_t;

    // answer of the remainder unit
    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] remainder;
    } rem_rsp_t;

endpackage

`default_nettype wire

>>> hdl/prh_if.sv
// prh_if: valid/ready channels of the rolling hash unit, byte input and
// hash output; depends on prh_pkg for the payload widths
`default_nettype none

interface prh_in_if;
    logic                       valid;
    logic                       ready;
    logic [prh_pkg::BYTE_W-1:0] data_byte;
    logic                       first_byte;
    logic                       last_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, input ready);
    modport sink (input valid, input data_byte, input first_byte,
                  input last_byte, output ready);
endinterface

interface prh_out_if;
    logic                       valid;
    logic                       ready;
    logic [prh_pkg::HASH_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

>>> hdl/prh_cfg_regs.sv
// prh_cfg_regs: APB-style register file holding multiplier and modulus
// depends on prh_pkg
`default_nettype none

module prh_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [prh_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [prh_pkg::PDATA_W-1:0]   pwdata,
    output logic      [prh_pkg::PDATA_W-1:0]   prdata,
    output prh_pkg::cfg_t                      cfg
);

    logic                            wr_en;
    logic [prh_pkg::REG_IDX_W-1:0]   reg_idx;
    logic [prh_pkg::HASH_W-1:0]      multiplier_reg;
    logic [prh_pkg::HASH_W-1:0]      multiplier_next;
    logic [prh_pkg::HASH_W-1:0]      modulus_reg;
    logic [prh_pkg::HASH_W-1:0]      modulus_next;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[prh_pkg::PADDR_W-1:2];

    // write decode
    always_comb
    begin
        multiplier_next = multiplier_reg;
        modulus_next    = modulus_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                prh_pkg::REG_MULTIPLIER: multiplier_next = pwdata[prh_pkg::HASH_W-1:0];
                prh_pkg::REG_MODULUS:    modulus_next    = pwdata[prh_pkg::HASH_W-1:0];
                default:                 multiplier_next = multiplier_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            multiplier_reg <= prh_pkg::RESET_MULTIPLIER;
            modulus_reg    <= prh_pkg::RESET_MODULUS;
        end
        else
        begin
            multiplier_reg <= multiplier_next;
            modulus_reg    <= modulus_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            prh_pkg::REG_MULTIPLIER: prdata = prh_pkg::PDATA_W'(multiplier_reg);
            prh_pkg::REG_MODULUS:    prdata = prh_pkg::PDATA_W'(modulus_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.multiplier = multiplier_reg;
    assign cfg.modulus    = modulus_reg;

endmodule

`default_nettype wire

>>> hdl/prh_rem_unit.sv
// prh_rem_unit: bit-serial remainder of a 64-bit word by a 32-bit modulus,
// one compare-subtract per cycle; a zero modulus keeps the low 32 bits
// depends on prh_pkg
`default_nettype none

module prh_rem_unit (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire prh_pkg::rem_req_t req,
    output prh_pkg::rem_rsp_t rsp
);

    logic                          busy_reg;
    logic                          busy_next;
    logic                          done_reg;
    logic                          done_next;
    logic [prh_pkg::CNT_W-1:0]     cnt_reg;
    logic [prh_pkg::CNT_W-1:0]     cnt_next;
    logic [prh_pkg::ACC_W-1:0]     shift_reg;
    logic [prh_pkg::ACC_W-1:0]     shift_next;
    logic [prh_pkg::HASH_W-1:0]    rem_reg;
    logic [prh_pkg::HASH_W-1:0]    rem_next;
    logic [prh_pkg::HASH_W-1:0]    div_reg;
    logic [prh_pkg::HASH_W-1:0]    div_next;
    logic [prh_pkg::HASH_W:0]      trial;
    logic [prh_pkg::HASH_W:0]      diff;
    logic                          fits;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign trial = {rem_reg, shift_reg[prh_pkg::ACC_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (req.start)
        begin
            div_next = req.divisor;
            if (req.divisor == '0)
            begin
                // modulus of zero stands for 2^32
                rem_next  = req.dividend[prh_pkg::HASH_W-1:0];
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                shift_next = req.dividend;
                rem_next   = '0;
                cnt_next   = '1;
                busy_next  = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[prh_pkg::HASH_W-1:0] : trial[prh_pkg::HASH_W-1:0];
            shift_next = {shift_reg[prh_pkg::ACC_W-2:0], 1'b0};
            cnt_next   = cnt_reg - prh_pkg::CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

    // partial remainder never reaches the modulus
    a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < div_reg)
        else $error("partial remainder not below modulus");

    // the serial loop only runs for a nonzero modulus
    a_busy_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> div_reg != '0)
        else $error("serial remainder running on zero modulus");

    // a new start is never issued while a division is in flight
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("remainder unit restarted while busy");

endmodule

`default_nettype wire

>>> hdl/polynomial_rolling_hash_unit.sv
// Polynomial rolling hash unit. Each accepted byte passes in order through
// the 32x32 multiply-accumulate h*multiplier+byte, the bit-serial remainder
// by the modulus (one compare-subtract per cycle in the remainder unit) and
// the write-back of the running hash, before the unit returns to idle to
// take the next byte. With a modulus of zero the step keeps the low 32 bits.
// Only one byte is in work at a time; the hash of a finished string sits in
// an output register, so the next byte is taken while that word waits.
// The user must write multiplier and modulus through the APB port only
// while the unit is idle; the block itself does not enforce this.
// depends on prh_pkg, prh_if, prh_cfg_regs, prh_rem_unit
`default_nettype none

module polynomial_rolling_hash_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    prh_in_if.sink                             in_chan,
    prh_out_if.source                          out_chan,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [prh_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [prh_pkg::PDATA_W-1:0]   pwdata,
    output logic      [prh_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_RED  = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    prh_pkg::cfg_t                  cfg;
    prh_pkg::rem_req_t              rem_req;
    prh_pkg::rem_rsp_t              rem_rsp;

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [prh_pkg::HASH_W-1:0]     hash_reg;
    logic [prh_pkg::HASH_W-1:0]     hash_next;
    logic [prh_pkg::HASH_W-1:0]     operand_reg;
    logic [prh_pkg::HASH_W-1:0]     operand_next;
    logic [prh_pkg::BYTE_W-1:0]     byte_reg;
    logic [prh_pkg::BYTE_W-1:0]     byte_next;
    logic                           last_reg;
    logic                           last_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [prh_pkg::HASH_W-1:0]     hash_out_reg;
    logic [prh_pkg::HASH_W-1:0]     hash_out_next;
    logic [prh_pkg::ACC_W-1:0]      mac;
    logic                           in_fire;
    logic                           slot_free;

    assign pready = 1'b1;

    prh_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // multiply-accumulate feeding the remainder unit's load register
    assign mac = prh_pkg::ACC_W'(operand_reg) * prh_pkg::ACC_W'(cfg.multiplier)
               + prh_pkg::ACC_W'(byte_reg);

    assign rem_req.start    = (state_reg == S_MUL);
    assign rem_req.dividend = mac;
    assign rem_req.divisor  = cfg.modulus;

    prh_rem_unit u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    assign in_chan.ready = (state_reg == S_IDLE);
    assign in_fire       = in_chan.valid && in_chan.ready;
    assign slot_free     = !out_valid_reg || out_chan.ready;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        operand_next   = operand_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_chan.ready;
        hash_out_next  = hash_out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    operand_next = in_chan.first_byte ? '0 : hash_reg;
                    byte_next    = in_chan.data_byte;
                    last_next    = in_chan.last_byte;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_RED;
            end
            S_RED:
            begin
                if (rem_rsp.done)
                begin
                    if (!last_reg)
                    begin
                        hash_next  = rem_rsp.remainder;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        hash_next = '0;
                        if (slot_free)
                        begin
                            out_valid_next = 1'b1;
                            hash_out_next  = rem_rsp.remainder;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_HOLD;
                        end
                    end
                end
            end
            S_HOLD:
            begin
                // result waits in the remainder unit until the output word frees
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    hash_out_next  = rem_rsp.remainder;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hash_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        operand_reg  <= operand_next;
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        hash_out_reg <= hash_out_next;
    end

    assign out_chan.valid      = out_valid_reg;
    assign out_chan.hash_value = hash_out_reg;

    // an accepted word always goes to the multiply step
    a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_MUL)
        else $error("accepted word did not enter multiply step");

    // the remainder unit only reports back while the sequencer waits for it
    a_done_in_red: assert property (@(posedge clk) disable iff (!rst_n)
        rem_rsp.done |-> state_reg == S_RED)
        else $error("remainder done outside reduce state");

    // a finished string leaves the running hash cleared
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RED && rem_rsp.done && last_reg) |=> hash_reg == '0)
        else $error("running hash not cleared after last byte");

endmodule

`default_nettype wire

>>> dv/polynomial_rolling_hash_unit_tb.sv
// polynomial_rolling_hash_unit_tb: self-checking bench for the rolling hash unit,
// drives bytes and APB register writes, predicts each string hash and compares it
// depends on prh_pkg, prh_if and the polynomial_rolling_hash_unit rtl

module polynomial_rolling_hash_unit_tb;

    localparam int CLK_PERIOD  = 12;
    localparam int IDLE_WAIT   = 80;    // covers a byte still in work
    localparam int STALL_LIMIT = 4000;  // cycles without any accepted word
    localparam int RANDOM_WORDS = 1626;

    logic clk;
    logic rst_n;

    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [prh_pkg::PADDR_W-1:0]  paddr;
    logic [prh_pkg::PDATA_W-1:0]  pwdata;
    logic [prh_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    prh_in_if  in_ch ();
    prh_out_if out_ch ();

    // predictor state and register mirror
    logic [prh_pkg::HASH_W-1:0] running_hash_q;
    logic [prh_pkg::HASH_W-1:0] cfg_multiplier;
    logic [prh_pkg::HASH_W-1:0] cfg_modulus;
    logic [prh_pkg::HASH_W-1:0] hashes_due [$];

    int mismatch_cnt;
    int src_idle_pct;
    int sink_idle_pct;
    int stall_cnt;

    polynomial_rolling_hash_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_ch),
        .out_chan (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // one multiply-accumulate-reduce step, modulus zero keeps the low 32 bits
    function automatic logic [prh_pkg::HASH_W-1:0] next_hash(
        input logic [prh_pkg::HASH_W-1:0] h,
        input logic [prh_pkg::BYTE_W-1:0] c);
        logic [prh_pkg::ACC_W-1:0] acc;
        acc = prh_pkg::ACC_W'(h) * prh_pkg::ACC_W'(cfg_multiplier) + prh_pkg::ACC_W'(c);
        if (cfg_modulus == '0)
            return acc[prh_pkg::HASH_W-1:0];
        return prh_pkg::HASH_W'(acc % prh_pkg::ACC_W'(cfg_modulus));
    endfunction

    function automatic logic [prh_pkg::BYTE_W-1:0] pick_byte();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return prh_pkg::BYTE_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [prh_pkg::HASH_W-1:0] pick_multiplier();
        case ($urandom_range(5))
            0: return '0;
            1: return prh_pkg::HASH_W'(1);
            2: return '1;
            3: return prh_pkg::RESET_MULTIPLIER;
            default: return prh_pkg::HASH_W'($urandom);
        endcase
    endfunction

    function automatic logic [prh_pkg::HASH_W-1:0] pick_modulus();
        case ($urandom_range(6))
            0: return '0;
            1: return prh_pkg::HASH_W'(1);
            2: return '1;
            3: return prh_pkg::HASH_W'($urandom_range(2, 300));
            4: return prh_pkg::RESET_MODULUS;
            default: return prh_pkg::HASH_W'($urandom);
        endcase
    endfunction

    // send one byte word, with random idle cycles before it
    task automatic send_byte(input logic [prh_pkg::BYTE_W-1:0] b, input logic f,
                             input logic l);
        logic [prh_pkg::HASH_W-1:0] h;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.first_byte <= f;
        in_ch.last_byte  <= l;
        do
            @(posedge clk);
        while (!in_ch.ready);
        // word accepted, update the predicted running hash
        h = next_hash(f ? '0 : running_hash_q, b);
        if (l)
        begin
            hashes_due.push_back(h);
            running_hash_q = '0;
        end
        else
        begin
            running_hash_q = h;
        end
    endtask

    task automatic end_burst();
        in_ch.valid <= 1'b0;
    endtask

    // wait for all hashes, then for a byte still in work without a result
    task automatic settle();
        while (hashes_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic reg_write(input logic [prh_pkg::REG_IDX_W-1:0] idx,
                             input logic [prh_pkg::HASH_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == prh_pkg::REG_MULTIPLIER)
            cfg_multiplier = value;
        else
            cfg_modulus = value;
        @(posedge clk);
    endtask

    task automatic reg_check(input logic [prh_pkg::REG_IDX_W-1:0] idx,
                             input logic [prh_pkg::HASH_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            $display("%0t: register %0d readback: expected %08h, actual %08h",
                     $time, idx, want, prdata);
            mismatch_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_string(input logic [prh_pkg::BYTE_W-1:0] bytes [],
                               input logic marked);
        for (int i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], marked && (i == 0), i == bytes.size() - 1);
    endtask

    // reset values read back, then every register written and read
    task automatic test_registers();
        reg_check(prh_pkg::REG_MULTIPLIER, prh_pkg::RESET_MULTIPLIER);
        reg_check(prh_pkg::REG_MODULUS, prh_pkg::RESET_MODULUS);
        reg_write(prh_pkg::REG_MULTIPLIER, 32'hA5A5_5A5A);
        reg_write(prh_pkg::REG_MODULUS, 32'h5A5A_A5A5);
        reg_check(prh_pkg::REG_MULTIPLIER, 32'hA5A5_5A5A);
        reg_check(prh_pkg::REG_MODULUS, 32'h5A5A_A5A5);
        reg_write(prh_pkg::REG_MULTIPLIER, prh_pkg::RESET_MULTIPLIER);
        reg_write(prh_pkg::REG_MODULUS, prh_pkg::RESET_MODULUS);
    endtask

    // one-byte strings, a plain string, a string with no first mark, a restart
    task automatic test_reset_strings();
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_string('{8'hFF, 8'h80, 8'h7F}, 1'b1);
        send_string('{8'h55, 8'hAA}, 1'b0);
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(8'h34, 1'b1, 1'b0);
        send_byte(8'h56, 1'b0, 1'b1);
        end_burst();
        settle();
    endtask

    // modulus zero, one and all ones, multiplier zero and all ones
    task automatic test_register_extremes();
        reg_write(prh_pkg::REG_MULTIPLIER, '1);
        reg_write(prh_pkg::REG_MODULUS, '0);
        send_string('{8'hFF, 8'hFF, 8'hFF}, 1'b1);
        end_burst();
        settle();
        reg_write(prh_pkg::REG_MULTIPLIER, prh_pkg::RESET_MULTIPLIER);
        reg_write(prh_pkg::REG_MODULUS, prh_pkg::HASH_W'(1));
        send_string('{8'hC3, 8'h3C}, 1'b1);
        end_burst();
        settle();
        reg_write(prh_pkg::REG_MULTIPLIER, '1);
        reg_write(prh_pkg::REG_MODULUS, '1);
        send_string('{8'hFF, 8'h01, 8'hFE}, 1'b1);
        end_burst();
        settle();
        reg_write(prh_pkg::REG_MULTIPLIER, '0);
        reg_write(prh_pkg::REG_MODULUS, prh_pkg::HASH_W'(2));
        send_string('{8'hFE, 8'hFF}, 1'b1);
        end_burst();
        settle();
    endtask

    // registers rewritten while a string is open
    task automatic test_mid_string_update();
        reg_write(prh_pkg::REG_MULTIPLIER, prh_pkg::RESET_MULTIPLIER);
        reg_write(prh_pkg::REG_MODULUS, prh_pkg::RESET_MODULUS);
        send_byte(8'hDE, 1'b1, 1'b0);
        send_byte(8'hAD, 1'b0, 1'b0);
        end_burst();
        settle();
        reg_write(prh_pkg::REG_MODULUS, 32'hFFFF_FFFB);
        send_byte(8'hBE, 1'b0, 1'b0);
        end_burst();
        settle();
        reg_write(prh_pkg::REG_MULTIPLIER, 32'h0001_0003);
        send_byte(8'hEF, 1'b0, 1'b1);
        end_burst();
        settle();
    endtask

    // random strings in blocks, registers changed between blocks
    task automatic test_random_phase(input int src_pct, input int snk_pct, input int n_words);
        int sent;
        int len;
        int shape;
        logic f;
        logic l;
        src_idle_pct  = src_pct;
        sink_idle_pct = snk_pct;
        for (int blk = 0; blk < 5; blk++)
        begin
            settle();
            reg_write(prh_pkg::REG_MULTIPLIER, pick_multiplier());
            reg_write(prh_pkg::REG_MODULUS, pick_modulus());
            sent = 0;
            while (sent < n_words / 5)
            begin
                // mostly well-formed strings, some with random marks
                shape = $urandom_range(99);
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                               : $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                begin
                    if (shape < 80)
                    begin
                        f = (i == 0);
                        l = (i == len - 1);
                    end
                    else
                    begin
                        f = ($urandom_range(3) == 0);
                        l = ($urandom_range(3) == 0);
                    end
                    send_byte(pick_byte(), f, l);
                end
                sent += len;
            end
            end_burst();
        end
        settle();
    endtask

    // hash receiver and checker
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (hashes_due.size() == 0)
                begin
                    $display("%0t: hash word with none pending: expected none, actual %08h",
                             $time, out_ch.hash_value);
                    mismatch_cnt++;
                end
                else if (out_ch.hash_value !== hashes_due[0])
                begin
                    $display("%0t: hash mismatch: expected %08h, actual %08h",
                             $time, hashes_due[0], out_ch.hash_value);
                    mismatch_cnt++;
                    void'(hashes_due.pop_front());
                end
                else
                begin
                    void'(hashes_due.pop_front());
                end
            end
            out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // watchdog on cycles without any accepted word
    initial
    begin
        stall_cnt = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("%0t: timeout, %0d hashes still pending", $time, hashes_due.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.first_byte = 1'b0;
        in_ch.last_byte  = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        mismatch_cnt     = 0;
        src_idle_pct     = 24;
        sink_idle_pct    = 62;
        running_hash_q   = '0;
        cfg_multiplier   = prh_pkg::RESET_MULTIPLIER;
        cfg_modulus      = prh_pkg::RESET_MODULUS;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_registers();
        test_reset_strings();
        test_register_extremes();
        test_mid_string_update();
        test_random_phase(24, 62, RANDOM_WORDS / 3);
        test_random_phase(62, 24, RANDOM_WORDS / 3);
        test_random_phase(0, 0, RANDOM_WORDS / 3);

        settle();
        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
hdl/prh_pkg.sv
hdl/prh_if.sv
hdl/prh_cfg_regs.sv
hdl/prh_rem_unit.sv
hdl/polynomial_rolling_hash_unit.sv
dv/polynomial_rolling_hash_unit_tb.sv
